@@ src/fbtc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbtc_pkg
// Types and codes shared by the framebuffer texture cache modules.
// ----------------------------------------------------------------------------
package fbtc_pkg;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] texture;
        logic        tiled;
        logic [31:0] size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
    localparam int SLOT_W  = 3;

    typedef struct packed {
        logic [31:0] start;
        logic        tiled;
        logic [31:0] size;
        logic [31:0] texture;
    } req_t;

    typedef struct packed {
        logic exact;
        logic mismatch;
    } cmp_t;

    typedef enum logic [1:0] {
        STATUS_UNCHANGED = 2'd0,
        STATUS_HIT       = 2'd1,
        STATUS_MISS      = 2'd2,
        STATUS_NO_BUFFER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_FINISH,
        ST_EMIT
    } state_t;

endpackage

@@ src/framebuffer_texture_cache.sv @@
// ----------------------------------------------------------------------------
// framebuffer_texture_cache
// Maps displayed framebuffer start addresses to texture handles, replacing
// the oldest entry by age on a miss, or entry 0 after flushing a stale table.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request with no buffer, or with an
// unchanged start address, goes straight to the emit state. A changed
// address makes a pass: the entry memory is read one entry per cycle
// through its single read port while each entry is compared until a hit or
// a mismatch and each valid entry is aged and written back, then the finish
// state writes the replaced entry on a miss and the emit state loads the
// result register. A result waiting on m_ready delays the end of the next
// request. Reset leaves every entry empty at once through per-entry valid
// bits; no clearing pass is needed, and a stale-table flush clears them too.
// ----------------------------------------------------------------------------
module framebuffer_texture_cache #(
    parameter int ENTRIES  = 8,
    parameter int AGE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_buffer_present,
    input  logic [31:0] s_fb_start,
    input  logic        s_fb_tiled,
    input  logic [31:0] s_fb_size,
    input  logic [31:0] s_new_texture_id,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_slot,
    output logic [31:0] m_texture_id,
    output logic [31:0] m_fb_addr
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W = AGE_BITS + fbtc_pkg::ENTRY_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    fbtc_pkg::state_t    state_reg, state_next;
    fbtc_pkg::req_t      req_reg, req_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic                def_tiled_reg, def_tiled_next;
    logic [31:0]         def_size_reg, def_size_next;
    logic [31:0]         cur_addr_reg, cur_addr_next;
    logic [31:0]         cur_tex_reg, cur_tex_next;
    logic                table_valid_reg, table_valid_next;
    logic                scanning_reg, scanning_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [31:0]         hit_tex_reg, hit_tex_next;
    logic [AGE_BITS-1:0] best_age_reg, best_age_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    fbtc_pkg::status_t   res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [2:0]          m_slot_reg, m_slot_next;
    logic [31:0]         m_tex_reg, m_tex_next;
    logic [31:0]         m_addr_reg, m_addr_next;

    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    fbtc_pkg::cmp_t      cmp;
    fbtc_pkg::entry_t    entry;
    fbtc_pkg::entry_t    fill_entry;
    logic [AGE_BITS-1:0] age_inc;
    logic [WORD_W-1:0]   aged_word;
    logic                zero_age;
    logic [IDX_W-1:0]    fill_idx;

    fbtc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fbtc_entry_eval #(
        .AGE_BITS (AGE_BITS)
    ) u_eval (
        .rd_word   (ram_rd_data),
        .rd_valid  (valid_reg[idx_reg]),
        .def_tiled (def_tiled_reg),
        .def_size  (def_size_reg),
        .req       (req_reg),
        .zero_age  (zero_age),
        .cmp       (cmp),
        .entry     (entry),
        .age_next  (age_inc),
        .wr_word   (aged_word)
    );

    assign zero_age = scanning_reg && cmp.exact;
    assign fill_idx = table_valid_reg ? pick_reg : '0;

    always_comb begin
        fill_entry.start   = req_reg.start;
        fill_entry.texture = req_reg.texture;
        fill_entry.tiled   = req_reg.tiled;
        fill_entry.size    = req_reg.size;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fbtc_pkg::ST_IDLE;
            valid_reg       <= '0;
            def_tiled_reg   <= 1'b0;
            def_size_reg    <= '0;
            cur_addr_reg    <= '0;
            cur_tex_reg     <= '0;
            table_valid_reg <= 1'b0;
            scanning_reg    <= 1'b0;
            hit_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            def_tiled_reg   <= def_tiled_next;
            def_size_reg    <= def_size_next;
            cur_addr_reg    <= cur_addr_next;
            cur_tex_reg     <= cur_tex_next;
            table_valid_reg <= table_valid_next;
            scanning_reg    <= scanning_next;
            hit_reg         <= hit_next;
            m_valid_reg     <= m_valid_next;
        end
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_tex_reg    <= hit_tex_next;
        best_age_reg   <= best_age_next;
        pick_reg       <= pick_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_tex_reg      <= m_tex_next;
        m_addr_reg     <= m_addr_next;
    end

    always_comb begin
        state_next       = state_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        valid_next       = valid_reg;
        def_tiled_next   = def_tiled_reg;
        def_size_next    = def_size_reg;
        cur_addr_next    = cur_addr_reg;
        cur_tex_next     = cur_tex_reg;
        table_valid_next = table_valid_reg;
        scanning_next    = scanning_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_tex_next     = hit_tex_reg;
        best_age_next    = best_age_reg;
        pick_next        = pick_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_slot_next      = m_slot_reg;
        m_tex_next       = m_tex_reg;
        m_addr_next      = m_addr_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = idx_reg;
        ram_wr_data      = aged_word;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = '0;
        s_ready          = 1'b0;

        unique case (state_reg)
            fbtc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next.start   = s_fb_start;
                    req_next.tiled   = s_fb_tiled;
                    req_next.size    = s_fb_size;
                    req_next.texture = s_new_texture_id;
                    res_slot_next    = '0;
                    if (!s_buffer_present || s_fb_start == '0) begin
                        cur_addr_next    = '0;
                        table_valid_next = 1'b0;
                        res_status_next  = fbtc_pkg::STATUS_NO_BUFFER;
                        state_next       = fbtc_pkg::ST_EMIT;
                    end else if (s_fb_start == cur_addr_reg) begin
                        res_status_next = fbtc_pkg::STATUS_UNCHANGED;
                        state_next      = fbtc_pkg::ST_EMIT;
                    end else begin
                        ram_rd_en     = 1'b1;
                        idx_next      = '0;
                        scanning_next = 1'b1;
                        hit_next      = 1'b0;
                        state_next    = fbtc_pkg::ST_PASS;
                    end
                end
            end

            fbtc_pkg::ST_PASS: begin
                // read ahead while the current entry is aged and, if valid, written back
                ram_rd_en   = (idx_reg != LAST_IDX);
                ram_rd_addr = idx_reg + 1'b1;
                ram_wr_en   = valid_reg[idx_reg];
                if (scanning_reg) begin
                    if (cmp.exact) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = idx_reg;
                        hit_tex_next  = entry.texture;
                        scanning_next = 1'b0;
                    end else if (cmp.mismatch) begin
                        table_valid_next = 1'b0;
                        scanning_next    = 1'b0;
                    end
                end
                if (idx_reg == '0 || age_inc > best_age_reg) begin
                    best_age_next = age_inc;
                    pick_next     = idx_reg;
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = fbtc_pkg::ST_FINISH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            fbtc_pkg::ST_FINISH: begin
                cur_addr_next = req_reg.start;
                if (hit_reg) begin
                    cur_tex_next    = hit_tex_reg;
                    res_status_next = fbtc_pkg::STATUS_HIT;
                    res_slot_next   = hit_idx_reg;
                end else begin
                    // flush a stale table and fill entry 0, else fill the oldest entry
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = fill_idx;
                    ram_wr_data = {{AGE_BITS{1'b0}}, fill_entry};
                    if (!table_valid_reg) begin
                        valid_next       = '0;
                        def_tiled_next   = req_reg.tiled;
                        def_size_next    = req_reg.size;
                        table_valid_next = 1'b1;
                    end
                    valid_next[fill_idx] = 1'b1;
                    cur_tex_next         = req_reg.texture;
                    res_status_next      = fbtc_pkg::STATUS_MISS;
                    res_slot_next        = fill_idx;
                end
                state_next = fbtc_pkg::ST_EMIT;
            end

            fbtc_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = fbtc_pkg::SLOT_W'(res_slot_reg);
                    m_tex_next    = cur_tex_reg;
                    m_addr_next   = cur_addr_reg;
                    state_next    = fbtc_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = fbtc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot       = m_slot_reg;
    assign m_texture_id = m_tex_reg;
    assign m_fb_addr    = m_addr_reg;

endmodule

@@ src/fbtc_ram.sv @@
// ----------------------------------------------------------------------------
// fbtc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/fbtc_entry_eval.sv @@
// ----------------------------------------------------------------------------
// fbtc_entry_eval
// Decode one stored entry, compare it with the request and form its aged
// write-back word.
// ----------------------------------------------------------------------------
module fbtc_entry_eval #(
    parameter int AGE_BITS = 16
) (
    input  logic [AGE_BITS+fbtc_pkg::ENTRY_W-1:0] rd_word,
    input  logic                                  rd_valid,
    input  logic                                  def_tiled,
    input  logic [31:0]                           def_size,
    input  fbtc_pkg::req_t                        req,
    input  logic                                  zero_age,
    output fbtc_pkg::cmp_t                        cmp,
    output fbtc_pkg::entry_t                      entry,
    output logic [AGE_BITS-1:0]                   age_next,
    output logic [AGE_BITS+fbtc_pkg::ENTRY_W-1:0] wr_word
);

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    fbtc_pkg::entry_t    entry_raw;
    logic [AGE_BITS-1:0] age;

    always_comb begin
        entry_raw = rd_word[fbtc_pkg::ENTRY_W-1:0];
        if (rd_valid) begin
            entry = entry_raw;
            age   = rd_word[fbtc_pkg::ENTRY_W +: AGE_BITS];
        end else begin
            entry.start   = '0;
            entry.texture = '0;
            entry.tiled   = def_tiled;
            entry.size    = def_size;
            age           = AGE_MAX;
        end

        cmp.mismatch = (entry.tiled != req.tiled) || (entry.size != req.size);
        cmp.exact    = (entry.start == req.start) && !cmp.mismatch;

        // saturate at all ones
        age_next = (age == AGE_MAX) ? age : age + 1'b1;
        wr_word  = {(zero_age ? {AGE_BITS{1'b0}} : age_next), entry};
    end

endmodule

@@ src/fbtc_checker.sv @@
// ----------------------------------------------------------------------------
// fbtc_checker
// Port-level checks for the framebuffer texture cache, bound to the top level.
// ----------------------------------------------------------------------------
module fbtc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_buffer_present,
    input logic [31:0] s_fb_start,
    input logic        s_fb_tiled,
    input logic [31:0] s_fb_size,
    input logic [31:0] s_new_texture_id,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [2:0]  m_slot,
    input logic [31:0] m_texture_id,
    input logic [31:0] m_fb_addr
);

    default clocking cb @(posedge aclk);
    endclocking

    default disable iff (!aresetn);

    a_out_hold: assert property (
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot)
            && $stable(m_texture_id) && $stable(m_fb_addr))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");

    a_no_buffer: assert property (
        m_valid && m_status == fbtc_pkg::STATUS_NO_BUFFER |-> m_fb_addr == '0 && m_slot == '0)
        else $error("no-buffer result with address or slot set");

    a_unchanged_slot: assert property (
        m_valid && m_status == fbtc_pkg::STATUS_UNCHANGED |-> m_slot == '0)
        else $error("unchanged result with nonzero slot");

    a_lookup_addr: assert property (
        m_valid && (m_status == fbtc_pkg::STATUS_HIT || m_status == fbtc_pkg::STATUS_MISS)
            |-> m_fb_addr != '0)
        else $error("hit or miss result with zero address");

endmodule

bind framebuffer_texture_cache fbtc_checker u_fbtc_checker (.*);
